@@ hw/rtl/isp_pkg.sv @@
// Shared word types and field widths for the insertion sort permuter.
package isp_pkg;

    localparam int KEY_W   = 8;
    localparam int INDEX_W = 3;

    // One key word: an ordering key and the end-of-set mark
    typedef struct packed {
        logic signed [KEY_W-1:0] order_key;
        logic                    last_key;
    } key_word_t;

    // One result word: permutation entry, key and set flags
    typedef struct packed {
        logic [INDEX_W-1:0]      source_index;
        logic signed [KEY_W-1:0] sorted_key;
        logic                    overflow;
        logic                    last_result;
    } result_word_t;

endpackage

@@ hw/rtl/isp_stream_if.sv @@
// Valid/ready stream channel carrying one word of a given type.
interface isp_stream_if #(
    parameter type word_t = logic
) ();

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ hw/rtl/insertion_sort_permuter_core.sv @@
// Stable insertion sort permuter: loads keys, sorts them in a RAM, emits the permutation.
//
//  channel    | dir | word                 | notes
//  -----------+-----+----------------------+-------------------------------
//  key_ch     | in  | order_key, last_key  | one key per word
//  result_ch  | out | source_index,        | one word per held key,
//             |     | sorted_key, overflow,| ascending key order
//             |     | last_result          |
//
// The block takes keys only while loading. After the last key, each pass i of
// the sort reads entry i, then reads each earlier entry in turn and shifts it
// up while its key is strictly greater, then writes entry i into the gap; a
// final check ends the sort. Each result is then read from the RAM and loaded.
// All data sits in one single-port-read, single-port-write RAM with registered
// read data. Reset clears the state, counts and flags only.
// A stalled result holds in the output register; the next set can start
// loading while the final result still waits.
module insertion_sort_permuter_core #(
    parameter int MAX_ENTRIES = 8,
    parameter int KEY_BITS    = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    isp_stream_if.sink           key_ch,
    isp_stream_if.source         result_ch
);

    localparam int ADDR_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_W = KEY_BITS + ADDR_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_CUR,
        S_CMP,
        S_PLACE,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [ENTRY_W-1:0] cur_reg, cur_next;

    logic                           out_valid_reg, out_valid_next;
    logic [isp_pkg::INDEX_W-1:0]    out_index_reg, out_index_next;
    logic [isp_pkg::KEY_W-1:0]      out_key_reg, out_key_next;
    logic                           out_ovf_reg, out_ovf_next;
    logic                           out_last_reg, out_last_next;

    // RAM ports
    logic [ENTRY_W-1:0] entry_mem [MAX_ENTRIES];
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data_reg;

    logic                       key_acc;
    logic                       res_acc;
    logic [31:0]                raw_key32;
    logic [KEY_BITS-1:0]        new_key;
    logic signed [KEY_BITS-1:0] rd_key;
    logic signed [KEY_BITS-1:0] cur_key;
    logic signed [31:0]         rd_key32;
    logic [31:0]                rd_index32;
    logic [CNT_W-1:0]           j_dec;

    assign key_ch.ready    = (state_reg == S_LOAD);
    assign key_acc         = key_ch.valid && key_ch.ready;
    assign res_acc         = result_ch.valid && result_ch.ready;

    assign result_ch.valid             = out_valid_reg;
    assign result_ch.data.source_index = out_index_reg;
    assign result_ch.data.sorted_key   = out_key_reg;
    assign result_ch.data.overflow     = out_ovf_reg;
    assign result_ch.data.last_result  = out_last_reg;

    // Key narrowing: low KEY_BITS of the zero-extended field
    assign raw_key32  = {24'd0, key_ch.data.order_key};
    assign new_key    = raw_key32[KEY_BITS-1:0];

    // Entry layout: {key, arrival index}
    assign rd_key     = rd_data_reg[ENTRY_W-1 -: KEY_BITS];
    assign cur_key    = cur_reg[ENTRY_W-1 -: KEY_BITS];
    assign rd_key32   = 32'(rd_key);
    assign rd_index32 = 32'(rd_data_reg[ADDR_W-1:0]);
    assign j_dec      = j_reg - CNT_W'(1);

    // Address of the entry just below a position
    function automatic logic [ADDR_W-1:0] j_dec_of(input logic [CNT_W-1:0] pos);
        logic [CNT_W-1:0] below;
        below = pos - CNT_W'(1);
        return below[ADDR_W-1:0];
    endfunction

    // Sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_key_next   = out_key_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_addr        = j_reg[ADDR_W-1:0];
        wr_data        = cur_reg;
        rd_en          = 1'b0;
        rd_addr        = i_reg[ADDR_W-1:0];

        if (res_acc)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (key_acc)
                begin
                    if (count_reg < CNT_W'(MAX_ENTRIES))
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[ADDR_W-1:0];
                        wr_data    = {new_key, count_reg[ADDR_W-1:0]};
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (key_ch.data.last_key)
                    begin
                        i_next     = CNT_W'(1);
                        state_next = S_START;
                    end
                end
            end
            // Outer pass: fetch entry i or finish sorting
            S_START:
            begin
                if (i_reg >= count_reg)
                begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg[ADDR_W-1:0];
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                cur_next   = rd_data_reg;
                j_next     = i_reg;
                rd_en      = 1'b1;
                rd_addr    = j_dec_of(i_reg);
                state_next = S_CMP;
            end
            // Shift the earlier entry up while its key is strictly greater
            S_CMP:
            begin
                if (rd_key > cur_key)
                begin
                    wr_en   = 1'b1;
                    wr_addr = j_reg[ADDR_W-1:0];
                    wr_data = rd_data_reg;
                    j_next  = j_dec;
                    if (j_dec != '0)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = j_dec_of(j_dec);
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[ADDR_W-1:0];
                wr_data    = cur_reg;
                i_next     = i_reg + CNT_W'(1);
                state_next = S_START;
            end
            S_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg[ADDR_W-1:0];
                state_next = S_EMIT_LD;
            end
            // Load the output register once it is free
            S_EMIT_LD:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = rd_index32[isp_pkg::INDEX_W-1:0];
                    out_key_next   = rd_key32[isp_pkg::KEY_W-1:0];
                    out_ovf_next   = ovf_reg;
                    out_last_next  = ((k_reg + CNT_W'(1)) == count_reg);
                    k_next         = k_reg + CNT_W'(1);
                    if ((k_reg + CNT_W'(1)) == count_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_index_reg <= out_index_next;
        out_key_reg   <= out_key_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    // Entry RAM write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    // Entry RAM read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    // Held key count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("loaded key count above capacity");

    // The shift loop never runs past the bottom entry
    a_cmp_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (j_reg != '0))
        else $error("compare step at position zero");

    // Read and write never target the same entry in one cycle
    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("RAM read and write collide");

    // A new set starts loading only after the last result is loaded
    a_last_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD && state_next == S_LOAD) |=> (out_valid_reg && out_last_reg))
        else $error("set closed without a final result");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the insertion sort permuter core.
module tb_top;

    localparam int MAX_ENTRIES = 8;
    localparam int KEY_BITS    = 8;
    localparam int IDLE_PCT    = 29;
    localparam int TAIL_CYCLES = 128;
    localparam int DRAIN_LIMIT = 50000;

    logic clk;
    logic rst_n;

    isp_stream_if #(.word_t(isp_pkg::key_word_t))    key_ch ();
    isp_stream_if #(.word_t(isp_pkg::result_word_t)) result_ch ();

    insertion_sort_permuter_core #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .KEY_BITS   (KEY_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_ch   (key_ch),
        .result_ch(result_ch)
    );

    // Predictor state: keys held for the current set and their arrival positions
    logic signed [isp_pkg::KEY_W-1:0] held_keys [MAX_ENTRIES];
    logic [isp_pkg::INDEX_W-1:0]      held_pos  [MAX_ENTRIES];
    int                               held_count;
    logic                             keys_dropped;

    isp_pkg::result_word_t expected_perm_q [$];

    int mismatch_count;
    int keys_sent;
    int src_idle_pct;
    int sink_idle_pct;
    int sink_stall_left;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit, taken well above the slowest legal run
    initial
    begin
        #3000000;
        $display("insertion_sort_permuter_core regression: fail");
        $finish;
    end

    // Track one accepted key word; on the end of a set, sort and queue the permutation
    task automatic track_key(input isp_pkg::key_word_t w);
        logic signed [isp_pkg::KEY_W-1:0] k_tmp;
        logic [isp_pkg::INDEX_W-1:0]      p_tmp;
        isp_pkg::result_word_t            r;
        int                               i;
        int                               j;
        if (held_count < MAX_ENTRIES)
        begin
            held_keys[held_count] = w.order_key;
            held_pos[held_count]  = held_count[isp_pkg::INDEX_W-1:0];
            held_count++;
        end
        else
        begin
            keys_dropped = 1'b1;
        end
        if (w.last_key)
        begin
            // stable: swap only on strictly greater
            for (i = 1; i < held_count; i++)
            begin
                j = i;
                while (j > 0 && held_keys[j-1] > held_keys[j])
                begin
                    k_tmp          = held_keys[j];
                    p_tmp          = held_pos[j];
                    held_keys[j]   = held_keys[j-1];
                    held_pos[j]    = held_pos[j-1];
                    held_keys[j-1] = k_tmp;
                    held_pos[j-1]  = p_tmp;
                    j--;
                end
            end
            for (i = 0; i < held_count; i++)
            begin
                r.source_index = held_pos[i];
                r.sorted_key   = held_keys[i];
                r.overflow     = keys_dropped;
                r.last_result  = (i == held_count - 1);
                expected_perm_q.push_back(r);
            end
            held_count   = 0;
            keys_dropped = 1'b0;
        end
    endtask

    // Compare one result word against the oldest expected entry
    task automatic check_result(input isp_pkg::result_word_t got);
        isp_pkg::result_word_t want;
        if (expected_perm_q.size() == 0)
        begin
            $display("%0t: unexpected result word: idx=%0d key=%0d ovf=%0b last=%0b",
                     $time, got.source_index, got.sorted_key, got.overflow,
                     got.last_result);
            mismatch_count++;
        end
        else
        begin
            want = expected_perm_q.pop_front();
            if (got.source_index !== want.source_index)
            begin
                $display("%0t: source_index mismatch: expected %0d actual %0d",
                         $time, want.source_index, got.source_index);
                mismatch_count++;
            end
            if (got.sorted_key !== want.sorted_key)
            begin
                $display("%0t: sorted_key mismatch: expected %0d actual %0d",
                         $time, want.sorted_key, got.sorted_key);
                mismatch_count++;
            end
            if (got.overflow !== want.overflow)
            begin
                $display("%0t: overflow mismatch: expected %0b actual %0b",
                         $time, want.overflow, got.overflow);
                mismatch_count++;
            end
            if (got.last_result !== want.last_result)
            begin
                $display("%0t: last_result mismatch: expected %0b actual %0b",
                         $time, want.last_result, got.last_result);
                mismatch_count++;
            end
        end
    endtask

    // Result side: check accepted words, drive ready with random idling and stalls
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                check_result(result_ch.data);
            if (sink_stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                sink_stall_left--;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offer one key word, with random gaps before it; returns at the accepting edge
    task automatic send_key(input logic signed [isp_pkg::KEY_W-1:0] k, input logic last);
        isp_pkg::key_word_t w;
        w.order_key = k;
        w.last_key  = last;
        while ($urandom_range(99) < src_idle_pct)
        begin
            key_ch.valid <= 1'b0;
            @(posedge clk);
        end
        key_ch.valid <= 1'b1;
        key_ch.data  <= w;
        do
            @(posedge clk);
        while (!key_ch.ready);
        track_key(w);
        keys_sent++;
    endtask

    // Random key: full range, or a narrow band to force ties
    function automatic logic signed [isp_pkg::KEY_W-1:0] pick_key(input bit narrow);
        int v;
        if (narrow)
            v = int'($urandom_range(4)) - 2;
        else
            v = $urandom_range(255);
        return v[isp_pkg::KEY_W-1:0];
    endfunction

    task automatic send_random_set(input int len);
        bit narrow;
        int i;
        narrow = $urandom_range(2) == 0;
        for (i = 0; i < len; i++)
            send_key(pick_key(narrow), i == len - 1);
    endtask

    // Set length: mostly within capacity, sometimes full, sometimes beyond
    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return $urandom_range(MAX_ENTRIES, 1);
        else if (r < 85)
            return MAX_ENTRIES;
        else
            return $urandom_range(MAX_ENTRIES + 4, MAX_ENTRIES + 1);
    endfunction

    // Stop offering and wait for every expected word to come back
    task automatic wait_drained();
        int n;
        n = 0;
        key_ch.valid <= 1'b0;
        while (expected_perm_q.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    task automatic test_single_key();
        send_key(-8'sd128, 1'b1);
        wait_drained();
    endtask

    task automatic test_extreme_keys();
        send_key(8'sd127, 1'b0);
        send_key(-8'sd128, 1'b0);
        send_key(8'sd0, 1'b0);
        send_key(-8'sd1, 1'b1);
    endtask

    // Ties must keep arrival order
    task automatic test_equal_keys();
        send_key(8'sd5, 1'b0);
        send_key(8'sd5, 1'b0);
        send_key(-8'sd3, 1'b0);
        send_key(8'sd5, 1'b1);
    endtask

    // Reverse-ordered full set, then two dropped keys, the last one carrying the end mark
    task automatic test_overflow_drop();
        int i;
        for (i = 0; i < MAX_ENTRIES; i++)
            send_key(8'(100 - 30 * i), 1'b0);
        send_key(8'sd1, 1'b0);
        send_key(-8'sd128, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_sets(input int n_keys);
        int stop_at;
        stop_at = keys_sent + n_keys;
        while (keys_sent < stop_at)
        begin
            send_random_set(pick_len());
            if ($urandom_range(9) == 0)
                wait_drained();
        end
    endtask

    task automatic test_no_idle_stretch(input int n_keys);
        int stop_at;
        stop_at       = keys_sent + n_keys;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (keys_sent < stop_at)
            send_random_set(pick_len());
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
    endtask

    // Receiver holds off while full sets keep coming, so the input backs up
    task automatic test_output_backpressure();
        int i;
        wait_drained();
        sink_stall_left = 400;
        src_idle_pct    = 0;
        for (i = 0; i < 3; i++)
            send_random_set(MAX_ENTRIES);
        src_idle_pct = IDLE_PCT;
        wait_drained();
    endtask

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        key_ch.valid    = 1'b0;
        key_ch.data     = '0;
        held_count      = 0;
        keys_dropped    = 1'b0;
        mismatch_count  = 0;
        keys_sent       = 0;
        src_idle_pct    = IDLE_PCT;
        sink_idle_pct   = IDLE_PCT;
        sink_stall_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_key();
        test_extreme_keys();
        test_equal_keys();
        test_overflow_drop();
        test_random_sets(200);
        test_output_backpressure();
        test_no_idle_stretch(60);
        test_random_sets(40);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_perm_q.size() != 0)
        begin
            $display("%0t: %0d expected result words never arrived",
                     $time, expected_perm_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("insertion_sort_permuter_core regression: pass");
        else
            $display("insertion_sort_permuter_core regression: fail");
        $finish;
    end

endmodule

@@ insertion_sort_permuter_core.f @@
hw/rtl/isp_pkg.sv
hw/rtl/isp_stream_if.sv
hw/rtl/insertion_sort_permuter_core.sv
sim/tb_top.sv
